// ===== hdl/thadc_pkg.sv =====
`default_nettype none
package thadc_pkg;

  // configuration
  localparam int FS_W  = 12;
  localparam int RF_W  = 20;
  localparam int CFG_W = 20;
  localparam int CIX_W = 2;
  localparam logic [RF_W-1:0] RFIX_RST = 20'd10000;
  localparam logic [FS_W-1:0] FS_RST   = 12'd1023;

  typedef enum logic [CIX_W-1:0] {
    CFG_ON_TOP     = 2'd0,
    CFG_RFIX       = 2'd1,
    CFG_FULL_SCALE = 2'd2,
    CFG_SUPPLY     = 2'd3
  } cfg_idx_t;

  // datapath widths
  localparam int NUM_W    = 32;
  localparam int DEN_W    = 25;
  localparam int BPROD_W  = 49;
  localparam int LOG_FRAC = 30;
  localparam int EXP_W    = 5;
  localparam int Y_W      = 31;
  localparam int LOG_W    = 36;
  localparam int LQ_W     = 30;
  localparam int L2_W     = 34;
  localparam int L3_W     = 40;
  localparam int CO_W     = 34;
  localparam int C1M_W    = 29;
  localparam int C2M_W    = 23;
  localparam int C3M_W    = 20;
  localparam int P_W      = 36;
  localparam int INV_W    = 40;
  localparam int UI_W     = 38;
  localparam int DVD_W    = 48;
  localparam int Q_BITS   = 17;
  localparam int DC_W     = UI_W + Q_BITS;
  localparam int RW       = 72;
  localparam int MULT_SH  = 24;
  localparam int LN_SH    = 32;

  localparam logic [12:0]      R_REF      = 13'd5000;
  localparam logic [16:0]      BAND_SCALE = 17'd100000;
  localparam logic [25:0]      LN2_Q26    = 26'd46516320;
  localparam logic [DVD_W-1:0] TCK_NUM    = DVD_W'(100) << 40;

  // result limits, in hundredths of kelvin before the offset and in hundredths of degrees C after it
  localparam logic [Q_BITS-1:0]        TCK_HIGH     = 17'd47315;
  localparam logic [Q_BITS-1:0]        TCK_LOW      = 17'd22315;
  localparam logic signed [Q_BITS:0]   KELVIN_CENTI = 18'sd27315;
  localparam logic signed [15:0]       TEMP_HIGH    = 16'sd20000;
  localparam logic signed [15:0]       TEMP_LOW     = -16'sd5000;

  // coefficient bands
  localparam int N_BANDS = 4;
  localparam int N_LIM   = 5;
  localparam logic [2:0] BAND_NONE    = 3'd4;
  localparam logic [1:0] BAND_DEFAULT = 2'd1;
  // ratio * 100000; band k spans (lim[k+1], lim[k]]
  localparam logic [22:0] BAND_LIM [N_LIM] = '{
    23'd6860000, 23'd327400, 23'd36036, 23'd6831, 23'd1872
  };

  // decimal mantissas scaled to Q40: m * 2^(40-p) / 5^p, rounded
  localparam longint P10 = 64'd9765625;
  localparam longint P11 = 64'd48828125;
  localparam longint P13 = 64'd1220703125;
  localparam longint P15 = 64'd30517578125;

  localparam logic signed [CO_W-1:0] COEF [N_BANDS][4] = '{
    '{ CO_W'(((64'd33538646 << 30) + P10 / 2) / P10),
       CO_W'(((64'd25654090 << 29) + P11 / 2) / P11),
       CO_W'(((64'd19243889 << 27) + P13 / 2) / P13),
       CO_W'(((64'd109692440 << 25) + P15 / 2) / P15) },
    '{ CO_W'(((64'd33540154 << 30) + P10 / 2) / P10),
       CO_W'(((64'd25627725 << 29) + P11 / 2) / P11),
       CO_W'(((64'd20829210 << 27) + P13 / 2) / P13),
       CO_W'(((64'd73003206 << 25) + P15 / 2) / P15) },
    '{ CO_W'(((64'd33539264 << 30) + P10 / 2) / P10),
       CO_W'(((64'd25609446 << 29) + P11 / 2) / P11),
       CO_W'(((64'd19621987 << 27) + P13 / 2) / P13),
       CO_W'(((64'd46045930 << 25) + P15 / 2) / P15) },
    '{ CO_W'(((64'd33368620 << 30) + P10 / 2) / P10),
       CO_W'(((64'd24057263 << 29) + P11 / 2) / P11),
       -CO_W'(((64'd26687093 << 27) + P13 / 2) / P13),
       -CO_W'(((64'd407193550 << 25) + P15 / 2) / P15) }
  };

  // pipeline stage map
  localparam int S_NORM = 1;
  localparam int S_LOG0 = 2;
  localparam int S_LN   = S_LOG0 + LOG_FRAC;
  localparam int S_SQ   = S_LN + 1;
  localparam int S_CUBE = S_SQ + 1;
  localparam int S_P3   = S_CUBE + 1;
  localparam int S_SUM  = S_P3 + 1;
  localparam int S_DIV0 = S_SUM + 1;
  localparam int S_OUT  = S_DIV0 + Q_BITS + 1;
  localparam int NST    = S_OUT + 1;

  typedef struct packed {
    logic                     invalid;
    logic [2:0]               band;
    logic [NUM_W-1:0]         num;
    logic [DEN_W-1:0]         den;
    logic [Y_W-1:0]           yn;
    logic [Y_W-1:0]           yd;
    logic [EXP_W-1:0]         en;
    logic [EXP_W-1:0]         ed;
    logic [LOG_FRAC-1:0]      fn;
    logic [LOG_FRAC-1:0]      fd;
    logic signed [LQ_W-1:0]   lq;
    logic [L2_W-1:0]          l2;
    logic signed [L3_W-1:0]   l3;
    logic signed [P_W-1:0]    p1;
    logic signed [P_W-1:0]    p2;
    logic signed [P_W-1:0]    p3;
    logic                     nonpos;
    logic [UI_W-1:0]          ui;
    logic [DVD_W-1:0]         rem;
    logic                     ovf;
    logic [Q_BITS-1:0]        q;
    logic signed [15:0]       temp;
    logic                     sat;
  } pipe_t;

  function automatic logic [1:0] coef_row(input logic [2:0] band);
    return (band < BAND_NONE) ? band[1:0] : BAND_DEFAULT;
  endfunction

  function automatic logic [EXP_W-1:0] msb_pos(input logic [NUM_W-1:0] x);
    logic [EXP_W-1:0] e;
    e = '0;
    for (int b = 0; b < NUM_W; b++) if (x[b]) e = EXP_W'(b);
    return e;
  endfunction

  // round to nearest, ties away from zero, on a magnitude
  function automatic logic [RW-1:0] rnd_shr(input logic [RW-1:0] p, input int s);
    return (p + (RW'(1) << (s - 1))) >> s;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/thermistor_adc_to_temperature.sv =====
// Thermistor divider ADC sample to temperature in 0.01 C.
//
// Input channel (in_valid / in_stall / in_adc_code): one converter sample per
// request. Result channel (out_valid / out_stall / out_*): one result per
// request, in order: temperature, coefficient band, saturation and
// invalid-code flags.
// Configuration: cfg_we / cfg_index / cfg_wdata, written while idle.
// Throughput: one request per cycle unless the receiver stalls with a result
// waiting. Depth is set by the 30 log2 squaring stages and the 17 divider stages.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults: thermistor low, 10000 ohm, full scale 1023.
// When the receiver stalls with a result waiting, the whole pipeline holds;
// in_stall follows so nothing is lost or repeated. Bubbles travel as cleared
// valid bits.
`default_nettype none
module thermistor_adc_to_temperature
  import thadc_pkg::*;
#(
  parameter int ADC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ADC_BITS-1:0] in_adc_code,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_temp_centi_celsius,
  output logic [2:0]          out_coeff_band,
  output logic                out_saturated,
  output logic                out_invalid_code,
  input  logic                cfg_we,
  input  logic [CIX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  localparam int CMP_W = (ADC_BITS > FS_W) ? ADC_BITS : FS_W;

  // ---------------------------------------------------------------------
  // Configuration registers. Supply voltage cancels in the ratio and is
  // not kept.
  // ---------------------------------------------------------------------
  logic            on_top_r;
  logic [RF_W-1:0] rfix_r;
  logic [FS_W-1:0] fs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_top_r <= 1'b0;
      rfix_r   <= RFIX_RST;
      fs_r     <= FS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ON_TOP:     on_top_r <= cfg_wdata[0];
        CFG_RFIX:       rfix_r   <= cfg_wdata[RF_W-1:0];
        CFG_FULL_SCALE: fs_r     <= cfg_wdata[FS_W-1:0];
        CFG_SUPPLY:     ;
        default:        ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Entry: range check and resistance ratio num/den (ohms vs 5000 ohms).
  // ---------------------------------------------------------------------
  logic [CMP_W-1:0] code_x;
  logic [CMP_W-1:0] fs_x;
  logic [FS_W-1:0]  code12;
  logic [FS_W-1:0]  rest12;
  pipe_t            in_item;

  always_comb begin
    code_x  = CMP_W'(in_adc_code);
    fs_x    = CMP_W'(fs_r);
    code12  = code_x[FS_W-1:0];
    rest12  = fs_r - code12;
    in_item = '0;
    in_item.invalid = (code_x == '0) || (code_x >= fs_x);
    if (on_top_r) begin
      in_item.num = NUM_W'(rfix_r) * NUM_W'(rest12);
      in_item.den = DEN_W'(code12) * DEN_W'(R_REF);
    end else begin
      in_item.num = NUM_W'(rfix_r) * NUM_W'(code12);
      in_item.den = DEN_W'(rest12) * DEN_W'(R_REF);
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline: one global advance; valid bits shift with the data.
  // ---------------------------------------------------------------------
  pipe_t          st_r   [NST];
  pipe_t          st_nxt [1:NST-1];
  logic [NST-1:0] vld_r;
  logic           adv;

  assign adv      = !vld_r[NST-1] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= in_item;
      for (int i = 1; i < NST; i++) st_r[i] <= st_nxt[i];
    end
  end

  for (genvar i = 1; i < NST; i++) begin : g_stage
    pipe_t p;
    assign p = st_r[i-1];

    if (i == S_NORM) begin : g_norm
      // band select by exact rational compares; mantissa normalize for log2
      logic [NUM_W-1:0]   xn;
      logic [NUM_W-1:0]   xd;
      logic [EXP_W-1:0]   en_v;
      logic [EXP_W-1:0]   ed_v;
      logic [BPROD_W-1:0] lhs;
      logic [N_LIM-1:0]   le;
      always_comb begin
        st_nxt[i] = p;
        xn   = (p.num == '0) ? NUM_W'(1) : p.num;
        xd   = NUM_W'(p.den);
        en_v = msb_pos(xn);
        ed_v = msb_pos(xd);
        st_nxt[i].en = en_v;
        st_nxt[i].ed = ed_v;
        st_nxt[i].yn = Y_W'({xn, {LOG_FRAC{1'b0}}} >> en_v);
        st_nxt[i].yd = Y_W'({xd, {LOG_FRAC{1'b0}}} >> ed_v);
        lhs = BPROD_W'(p.num) * BPROD_W'(BAND_SCALE);
        for (int k = 0; k < N_LIM; k++) begin
          le[k] = lhs <= BPROD_W'(p.den) * BPROD_W'(BAND_LIM[k]);
        end
        st_nxt[i].band = BAND_NONE;
        for (int k = N_BANDS - 1; k >= 0; k--) begin
          if (le[k] && !le[k+1]) st_nxt[i].band = 3'(k);
        end
      end

    end else if (i < S_LN) begin : g_log
      // one fraction bit of log2 per stage, for num and den
      localparam int FB = LOG_FRAC - (i - S_LOG0 + 1);
      logic [2*Y_W-1:0] sq_n;
      logic [2*Y_W-1:0] sq_d;
      logic [Y_W:0]     tn;
      logic [Y_W:0]     td;
      always_comb begin
        st_nxt[i] = p;
        sq_n = (2*Y_W)'(p.yn) * (2*Y_W)'(p.yn);
        sq_d = (2*Y_W)'(p.yd) * (2*Y_W)'(p.yd);
        tn   = sq_n[LOG_FRAC +: Y_W+1];
        td   = sq_d[LOG_FRAC +: Y_W+1];
        if (tn[Y_W]) begin
          st_nxt[i].yn     = tn[Y_W:1];
          st_nxt[i].fn[FB] = 1'b1;
        end else begin
          st_nxt[i].yn = tn[Y_W-1:0];
        end
        if (td[Y_W]) begin
          st_nxt[i].yd     = td[Y_W:1];
          st_nxt[i].fd[FB] = 1'b1;
        end else begin
          st_nxt[i].yd = td[Y_W-1:0];
        end
      end

    end else if (i == S_LN) begin : g_ln
      // L = (log2 num - log2 den) * ln2, Q24
      logic signed [LOG_W-1:0]  dl;
      logic [LOG_W-1:0]         dmag;
      logic [LOG_W+25:0]        prod;
      logic [LQ_W-1:0]          m;
      always_comb begin
        st_nxt[i] = p;
        dl   = $signed({1'b0, p.en, p.fn}) - $signed({1'b0, p.ed, p.fd});
        dmag = dl[LOG_W-1] ? LOG_W'(-dl) : LOG_W'(dl);
        prod = (LOG_W+26)'(dmag) * (LOG_W+26)'(LN2_Q26);
        m    = LQ_W'(rnd_shr(RW'(prod), LN_SH));
        st_nxt[i].lq = dl[LOG_W-1] ? -$signed(m) : $signed(m);
      end

    end else if (i == S_SQ) begin : g_sq
      logic [LQ_W-2:0]        lmag;
      logic [2*LQ_W-3:0]      prod;
      always_comb begin
        st_nxt[i] = p;
        lmag = p.lq[LQ_W-1] ? (LQ_W-1)'(-p.lq) : (LQ_W-1)'(p.lq);
        prod = (2*LQ_W-2)'(lmag) * (2*LQ_W-2)'(lmag);
        st_nxt[i].l2 = L2_W'(rnd_shr(RW'(prod), MULT_SH));
      end

    end else if (i == S_CUBE) begin : g_cube
      // L^3, b*L and c*L^2 side by side
      logic [LQ_W-2:0]             lmag;
      logic [L2_W+LQ_W-2:0]        pr3;
      logic signed [CO_W-1:0]      c1;
      logic signed [CO_W-1:0]      c2;
      logic [C1M_W-1:0]            m1;
      logic [C2M_W-1:0]            m2;
      logic [C1M_W+LQ_W-2:0]       pr1;
      logic [C2M_W+L2_W-1:0]       pr2;
      logic [L3_W-1:0]             r3;
      logic [P_W-1:0]              r1;
      logic [P_W-1:0]              r2;
      always_comb begin
        st_nxt[i] = p;
        lmag = p.lq[LQ_W-1] ? (LQ_W-1)'(-p.lq) : (LQ_W-1)'(p.lq);
        c1   = COEF[coef_row(p.band)][1];
        c2   = COEF[coef_row(p.band)][2];
        m1   = c1[CO_W-1] ? C1M_W'(-c1) : C1M_W'(c1);
        m2   = c2[CO_W-1] ? C2M_W'(-c2) : C2M_W'(c2);
        pr3  = (L2_W+LQ_W-1)'(p.l2) * (L2_W+LQ_W-1)'(lmag);
        pr1  = (C1M_W+LQ_W-1)'(m1) * (C1M_W+LQ_W-1)'(lmag);
        pr2  = (C2M_W+L2_W)'(m2) * (C2M_W+L2_W)'(p.l2);
        r3   = L3_W'(rnd_shr(RW'(pr3), MULT_SH));
        r1   = P_W'(rnd_shr(RW'(pr1), MULT_SH));
        r2   = P_W'(rnd_shr(RW'(pr2), MULT_SH));
        st_nxt[i].l3 = p.lq[LQ_W-1] ? -$signed(r3) : $signed(r3);
        st_nxt[i].p1 = (c1[CO_W-1] ^ p.lq[LQ_W-1]) ? -$signed(r1) : $signed(r1);
        st_nxt[i].p2 = c2[CO_W-1] ? -$signed(r2) : $signed(r2);
      end

    end else if (i == S_P3) begin : g_p3
      logic signed [CO_W-1:0]  c3;
      logic [C3M_W-1:0]        m3;
      logic [L3_W-2:0]         lmag3;
      logic [C3M_W+L3_W-2:0]   pr;
      logic [P_W-1:0]          r;
      always_comb begin
        st_nxt[i] = p;
        c3    = COEF[coef_row(p.band)][3];
        m3    = c3[CO_W-1] ? C3M_W'(-c3) : C3M_W'(c3);
        lmag3 = p.l3[L3_W-1] ? (L3_W-1)'(-p.l3) : (L3_W-1)'(p.l3);
        pr    = (C3M_W+L3_W-1)'(m3) * (C3M_W+L3_W-1)'(lmag3);
        r     = P_W'(rnd_shr(RW'(pr), MULT_SH));
        st_nxt[i].p3 = (c3[CO_W-1] ^ p.l3[L3_W-1]) ? -$signed(r) : $signed(r);
      end

    end else if (i == S_SUM) begin : g_sum
      // 1/T in Q40
      logic signed [INV_W-1:0] inv;
      always_comb begin
        st_nxt[i] = p;
        inv = INV_W'(COEF[coef_row(p.band)][0]) + INV_W'(p.p1) + INV_W'(p.p2)
            + INV_W'(p.p3);
        st_nxt[i].nonpos = (inv <= 0);
        st_nxt[i].ui     = UI_W'(inv);
      end

    end else if (i == S_DIV0) begin : g_div0
      // dividend 100*2^40 + ui/2; quotient wider than Q_BITS saturates
      logic [DVD_W-1:0] dvd;
      always_comb begin
        st_nxt[i] = p;
        dvd = TCK_NUM + DVD_W'(p.ui >> 1);
        st_nxt[i].rem = dvd;
        st_nxt[i].ovf = DC_W'(dvd) >= (DC_W'(p.ui) << Q_BITS);
        st_nxt[i].q   = '0;
      end

    end else if (i < S_OUT) begin : g_div
      // restoring divider, one quotient bit per stage
      localparam int J = Q_BITS - 1 - (i - S_DIV0 - 1);
      logic [DC_W-1:0] sh;
      always_comb begin
        st_nxt[i] = p;
        sh = DC_W'(p.ui) << J;
        if (DC_W'(p.rem) >= sh) begin
          st_nxt[i].rem  = p.rem - DVD_W'(sh);
          st_nxt[i].q[J] = 1'b1;
        end
      end

    end else begin : g_out
      logic signed [Q_BITS:0] tq;
      always_comb begin
        st_nxt[i] = p;
        tq = $signed({1'b0, p.q}) - KELVIN_CENTI;
        st_nxt[i].sat = 1'b0;
        priority if (p.invalid) begin
          st_nxt[i].temp = '0;
          st_nxt[i].band = BAND_NONE;
        end else if (p.nonpos || p.ovf || (p.q > TCK_HIGH)) begin
          st_nxt[i].temp = TEMP_HIGH;
          st_nxt[i].sat  = 1'b1;
        end else if (p.q < TCK_LOW) begin
          st_nxt[i].temp = TEMP_LOW;
          st_nxt[i].sat  = 1'b1;
        end else begin
          st_nxt[i].temp = 16'(tq);
        end
      end
    end
  end

  assign out_valid              = vld_r[S_OUT];
  assign out_temp_centi_celsius = st_r[S_OUT].temp;
  assign out_coeff_band         = st_r[S_OUT].band;
  assign out_saturated          = st_r[S_OUT].sat;
  assign out_invalid_code       = st_r[S_OUT].invalid;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

  a_invalid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid_code |->
      out_coeff_band == BAND_NONE && out_temp_centi_celsius == 16'sd0 && !out_saturated)
    else $error("invalid code result not cleared");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_temp_centi_celsius == TEMP_HIGH || out_temp_centi_celsius == TEMP_LOW)
    else $error("saturated result off the limits");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temp_centi_celsius <= TEMP_HIGH && out_temp_centi_celsius >= TEMP_LOW)
    else $error("temperature out of range");

endmodule
`default_nettype wire

// ===== bench/thermistor_adc_to_temperature_tb.sv =====
`timescale 1ns / 1ps
module thermistor_adc_to_temperature_tb;
  import thadc_pkg::*;

  localparam int LATENCY    = 55;
  localparam int WATCHDOG   = 4000;
  localparam int RAND_ITEMS = 750;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [11:0] in_adc_code = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_temp_centi_celsius;
  logic [2:0] out_coeff_band;
  logic out_saturated;
  logic out_invalid_code;
  logic cfg_we = 1'b0;
  logic [CIX_W-1:0] cfg_index = CFG_ON_TOP;
  logic [CFG_W-1:0] cfg_wdata = '0;

  thermistor_adc_to_temperature #(.ADC_BITS(12)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_adc_code(in_adc_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_temp_centi_celsius(out_temp_centi_celsius),
    .out_coeff_band(out_coeff_band), .out_saturated(out_saturated),
    .out_invalid_code(out_invalid_code),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct packed {
    logic signed [15:0] temp;
    logic [2:0]         band;
    logic               sat;
    logic               inval;
  } reading_t;

  // predictor's copy of the registers
  logic        sh_on_top;
  logic [19:0] sh_rfix;
  logic [11:0] sh_fs;
  logic [12:0] sh_supply;

  reading_t pending_readings[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_sat = 0;
  int n_invalid = 0;
  int band_hits[5] = '{0, 0, 0, 0, 0};
  int idle_cnt = 0;
  bit calm = 1'b0;    // no idling in the closing stretch

  function automatic longint mag64(input longint x);
    return x < 0 ? -x : x;
  endfunction

  // signed product rounded to nearest, ties away from zero
  function automatic longint prod_rnd(input longint x, input longint y, input int s);
    logic [127:0] p;
    p = 128'(mag64(x)) * 128'(mag64(y));
    p = (p + (128'd1 << (s - 1))) >> s;
    return ((x < 0) != (y < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint dec_to_q40(input longint m, input int p);
    longint five;
    longint v;
    five = 1;
    for (int i = 0; i < p; i++) five *= 5;
    v = ((mag64(m) << (40 - p)) + five / 2) / five;
    return m < 0 ? -v : v;
  endfunction

  // log2 of x >= 1, 30 fractional bits by repeated squaring
  function automatic longint log2_fix(input longint unsigned x);
    int e;
    longint unsigned y;
    longint unsigned fr;
    e = 63;
    fr = 0;
    while (e > 0 && x[e] == 1'b0) e--;
    y = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
    for (int i = 1; i <= 30; i++) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y >>= 1;
        fr |= 64'd1 << (30 - i);
      end
    end
    return (longint'(e) << 30) + longint'(fr);
  endfunction

  function automatic reading_t convert_sample(input logic [11:0] code);
    longint mant[4][4];
    int ex10[4];
    longint unsigned lim[5];
    longint unsigned num, den;
    longint co[4];
    longint lq, l2, l3, inv, t;
    longint unsigned tck;
    int band, row;
    reading_t r;
    mant = '{'{64'd33538646, 64'd25654090, 64'd19243889, 64'd109692440},
             '{64'd33540154, 64'd25627725, 64'd20829210, 64'd73003206},
             '{64'd33539264, 64'd25609446, 64'd19621987, 64'd46045930},
             '{64'd33368620, 64'd24057263, -64'd26687093, -64'd407193550}};
    ex10 = '{10, 11, 13, 15};
    lim = '{6860000, 327400, 36036, 6831, 1872};
    r = '0;
    if (code == 0 || code >= sh_fs) begin
      r.band = BAND_NONE;
      r.inval = 1'b1;
      return r;
    end
    if (sh_on_top) begin
      num = 64'(sh_rfix) * 64'(sh_fs - code);
      den = 64'(code) * 5000;
    end else begin
      num = 64'(sh_rfix) * 64'(code);
      den = 64'(sh_fs - code) * 5000;
    end
    band = 4;
    for (int k = 0; k < 4; k++)
      if (num * 100000 <= den * lim[k] && num * 100000 > den * lim[k + 1]) begin
        band = k;
        break;
      end
    row = band < 4 ? band : 1;
    for (int k = 0; k < 4; k++) co[k] = dec_to_q40(mant[row][k], ex10[k]);
    lq = prod_rnd(log2_fix(num == 0 ? 1 : num) - log2_fix(den), 46516320, 32);
    l2 = prod_rnd(lq, lq, 24);
    l3 = prod_rnd(l2, lq, 24);
    inv = co[0] + prod_rnd(co[1], lq, 24) + prod_rnd(co[2], l2, 24)
        + prod_rnd(co[3], l3, 24);
    if (inv <= 0) begin
      t = 20000;
      r.sat = 1'b1;
    end else begin
      tck = ((64'd100 << 40) + longint'(inv) / 2) / longint'(inv);
      t = longint'(tck) - 27315;
      if (t > 20000) begin t = 20000; r.sat = 1'b1; end
      if (t < -5000) begin t = -5000; r.sat = 1'b1; end
    end
    r.temp = 16'(t);
    r.band = 3'(band);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, n_checked);
  endtask

  // result side: random stall bursts, checking at each accepted result
  int stall_left = 0;
  always @(posedge clk) begin
    reading_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_readings.size() == 0) begin
          report_mismatch("unexpected result, temp", out_temp_centi_celsius, 0);
        end else begin
          want = pending_readings.pop_front();
          if (out_temp_centi_celsius !== want.temp)
            report_mismatch("temp_centi_celsius", out_temp_centi_celsius, want.temp);
          if (out_coeff_band !== want.band)
            report_mismatch("coeff_band", out_coeff_band, want.band);
          if (out_saturated !== want.sat)
            report_mismatch("saturated", out_saturated, want.sat);
          if (out_invalid_code !== want.inval)
            report_mismatch("invalid_code", out_invalid_code, want.inval);
          band_hits[want.band]++;
          n_sat += want.sat;
          n_invalid += want.inval;
        end
        n_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: cycles with no request or result accepted
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG) begin
      $display("watchdog expired, %0d results outstanding", pending_readings.size());
      $display("** thermistor_adc_to_temperature: FAILED **");
      $finish;
    end
  end

  // write enable stays high across a burst of writes; the caller lowers it
  task automatic write_reg(input cfg_idx_t idx, input logic [19:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_ON_TOP:     sh_on_top = val[0];
      CFG_RFIX:       sh_rfix = val;
      CFG_FULL_SCALE: sh_fs = val[11:0];
      default:        sh_supply = val[12:0];
    endcase
  endtask

  task automatic set_divider(input logic top, input logic [19:0] rf,
                             input logic [11:0] fs, input logic [12:0] mv);
    write_reg(CFG_ON_TOP, 20'(top));
    write_reg(CFG_RFIX, rf);
    write_reg(CFG_FULL_SCALE, 20'(fs));
    write_reg(CFG_SUPPLY, 20'(mv));
    cfg_we <= 1'b0;
  endtask

  // one request; an optional idle burst first. Valid stays high across
  // back-to-back requests, so it is never lowered and raised in one step.
  task automatic send_sample(input logic [11:0] code, input bit use_golden,
                             input reading_t golden);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_adc_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_readings.push_back(use_golden ? golden : convert_sample(code));
    n_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  typedef struct {
    logic [11:0] code;
    bit          golden;
    reading_t    want;
  } stim_row_t;

  stim_row_t directed_rows[$];

  task automatic add_row(input logic [11:0] code, input bit g, input reading_t w);
    stim_row_t s;
    s.code = code;
    s.golden = g;
    s.want = w;
    directed_rows.push_back(s);
  endtask

  initial begin
    reading_t bad;
    reading_t none;
    reading_t hot;
    bad = '{temp: 16'sd0, band: BAND_NONE, sat: 1'b0, inval: 1'b1};
    none = '0;
    hot = '{temp: 16'sd20000, band: BAND_NONE, sat: 1'b1, inval: 1'b0};

    sh_on_top = 1'b0;
    sh_rfix = RFIX_RST;
    sh_fs = FS_RST;
    sh_supply = 13'd3300;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: zero and at/above full scale are invalid
    add_row(12'd0, 1, bad);
    add_row(12'd1023, 1, bad);
    add_row(12'd4095, 1, bad);
    add_row(12'd1, 0, none);
    add_row(12'd1022, 0, none);
    add_row(12'd512, 0, none);
    add_row(12'd341, 0, none);
    add_row(12'd100, 0, none);
    add_row(12'd900, 0, none);
    add_row(12'd2048, 1, bad);
    foreach (directed_rows[i])
      send_sample(directed_rows[i].code, directed_rows[i].golden, directed_rows[i].want);
    drain();

    // zero fixed resistor, thermistor low: R = 0, very hot, clamped
    set_divider(1'b0, 20'd0, 12'd4095, 13'd1);
    directed_rows.delete();
    add_row(12'd1, 1, hot);
    add_row(12'd4094, 1, hot);
    add_row(12'd2048, 1, hot);
    add_row(12'd4095, 1, bad);
    foreach (directed_rows[i])
      send_sample(directed_rows[i].code, directed_rows[i].golden, directed_rows[i].want);
    drain();

    // full scale of zero makes every code invalid
    set_divider(1'b1, 20'd1000000, 12'd0, 13'd5000);
    send_sample(12'd0, 1, bad);
    send_sample(12'd1, 1, bad);
    send_sample(12'd4095, 1, bad);
    drain();

    // extremes with the thermistor on top
    set_divider(1'b1, 20'd1, 12'd4095, 13'd5000);
    send_sample(12'd1, 0, none);
    send_sample(12'd4094, 0, none);
    drain();
    set_divider(1'b1, 20'hFFFFF, 12'd1, 13'd1);
    send_sample(12'd1, 1, bad);
    drain();

    // random phases: realistic divider settings mostly, extremes sometimes
    for (int ph = 0; ph < 6; ph++) begin
      int count;
      logic [11:0] fs;
      fs = (ph == 5) ? 12'd4095 : 12'($urandom_range(16, 4095));
      if (ph == 2) fs = 12'd2;
      set_divider(1'($urandom_range(0, 1)),
                  (ph == 3) ? 20'hFFFFF : 20'($urandom_range(1000, 100000)),
                  fs, 13'($urandom_range(1, 8191)));
      calm = (ph == 5);
      count = RAND_ITEMS / 6;
      for (int i = 0; i < count; i++) begin
        logic [11:0] code;
        if ($urandom_range(0, 9) == 0) code = 12'($urandom);
        else code = 12'($urandom_range(1, (fs > 1) ? fs - 1 : 1));
        send_sample(code, 0, none);
        // hold off until everything has drained, once midway through phase 1
        if (ph == 1 && i == count / 2) begin
          in_valid <= 1'b0;
          while (pending_readings.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("%0d samples, %0d results; bands %0d/%0d/%0d/%0d/%0d, %0d clamped, %0d invalid",
             n_sent, n_checked, band_hits[0], band_hits[1], band_hits[2], band_hits[3],
             band_hits[4], n_sat, n_invalid);
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("** thermistor_adc_to_temperature: PASSED **");
    end else begin
      $display("** thermistor_adc_to_temperature: FAILED **");
    end
    $finish;
  end

endmodule
